// ===== rtl/core/top_k_sorted_insert_unit_assert.svh =====
// assertion macros for the top-k sorted insert unit
`ifndef TOP_K_SORTED_INSERT_UNIT_ASSERT_SVH
`define TOP_K_SORTED_INSERT_UNIT_ASSERT_SVH

`ifndef SYNTH
// same-cycle implication
`define TKSI_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// next-cycle implication
`define TKSI_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define TKSI_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define TKSI_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== rtl/core/tksi_pkg.sv =====
// shared types and constants of the top-k sorted insert unit
package tksi_pkg;

	localparam int LIST_DEPTH = 8;
	localparam int IDX_W      = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
	localparam int CNT_W      = $clog2(LIST_DEPTH + 1);
	localparam int RANK_W     = 3;
	localparam int SCORE_W    = 32;
	localparam int TAG_W      = 16;

	typedef logic signed [SCORE_W-1:0] score_t;
	typedef logic [TAG_W-1:0]          tag_t;
	typedef logic [IDX_W-1:0]          idx_t;
	typedef logic [CNT_W-1:0]          cnt_t;
	typedef logic [RANK_W-1:0]         rank_t;

	typedef struct packed {
		logic load;      // capture offered entry, restart rank
		logic insert;    // merge captured entry into list
		logic rank_inc;  // advance to next rank
	} cmd_t;

	typedef struct packed {
		logic last;      // current rank is the final entry
		cnt_t count;
	} sts_t;

endpackage

// ===== rtl/core/tksi_if.sv =====
// handshake channels of the top-k sorted insert unit
interface tksi_offer_if;
	logic             valid;
	logic             ready;
	tksi_pkg::score_t new_score;
	tksi_pkg::tag_t   new_tag;

	modport source (output valid, output new_score, output new_tag, input ready);
	modport sink (input valid, input new_score, input new_tag, output ready);
endinterface

interface tksi_result_if;
	logic             valid;
	logic             ready;
	tksi_pkg::rank_t  rank;
	tksi_pkg::score_t entry_score;
	tksi_pkg::tag_t   entry_tag;
	logic             last_entry;

	modport source (output valid, output rank, output entry_score, output entry_tag,
		output last_entry, input ready);
	modport sink (input valid, input rank, input entry_score, input entry_tag,
		input last_entry, output ready);
endinterface

// ===== rtl/core/tksi_ctrl.sv =====
// controller state machine of the top-k sorted insert unit
module tksi_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            offer_valid,
	output logic            offer_ready,
	output logic            result_valid,
	input  logic            result_ready,
	input  tksi_pkg::sts_t  sts,
	output tksi_pkg::cmd_t  cmd
);

	typedef enum logic [2:0] {
		S_IDLE   = 3'b001,
		S_INSERT = 3'b010,
		S_EMIT   = 3'b100
	} state_t;

	state_t state_q, state_d;
	logic   offer_beat, result_beat;

	always_comb begin
		offer_ready  = (state_q == S_IDLE);
		result_valid = (state_q == S_EMIT);
		offer_beat   = offer_valid && offer_ready;
		result_beat  = result_valid && result_ready;
		cmd.load     = offer_beat;
		cmd.insert   = (state_q == S_INSERT);
		cmd.rank_inc = result_beat && !sts.last;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (offer_beat) state_d = S_INSERT;
			end
			S_INSERT: begin
				state_d = S_EMIT;
			end
			S_EMIT: begin
				if (result_beat && sts.last) state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ===== rtl/core/tksi_datapath.sv =====
// list storage, insert network and rank readout of the top-k sorted insert unit
module tksi_datapath (
	input  logic             clk,
	input  logic             arst_n,
	input  tksi_pkg::cmd_t   cmd,
	output tksi_pkg::sts_t   sts,
	input  tksi_pkg::score_t new_score,
	input  tksi_pkg::tag_t   new_tag,
	output tksi_pkg::rank_t  rank,
	output tksi_pkg::score_t entry_score,
	output tksi_pkg::tag_t   entry_tag,
	output logic             last_entry
);

	localparam int D = tksi_pkg::LIST_DEPTH;
	localparam int CW = tksi_pkg::CNT_W;

	tksi_pkg::score_t score_q [D];
	tksi_pkg::tag_t   tag_q [D];
	tksi_pkg::score_t new_score_q;
	tksi_pkg::tag_t   new_tag_q;
	tksi_pkg::cnt_t   count_q;
	tksi_pkg::idx_t   rank_q;

	logic [D-1:0] ge;
	logic [D-1:0] put_new;
	logic [D-1:0] shift_in;
	logic         full;
	logic         take;

	assign full = (count_q == CW'(D));
	assign take = !full || (new_score_q > score_q[D-1]);

	// valid entries with equal or higher score form a prefix of the list
	genvar g;
	generate
		for (g = 0; g < D; g++) begin : g_entry
			assign ge[g] = (CW'(g) < count_q) && (score_q[g] >= new_score_q);
			if (g == 0) begin : g_head
				assign put_new[g]  = take && !ge[g];
				assign shift_in[g] = 1'b0;
			end else begin : g_body
				assign put_new[g]  = take && ge[g-1] && !ge[g];
				assign shift_in[g] = take && !ge[g-1] && (full || (CW'(g) <= count_q));
			end

			always_ff @(posedge clk) begin
				if (cmd.insert) begin
					if (put_new[g]) begin
						score_q[g] <= new_score_q;
						tag_q[g]   <= new_tag_q;
					end else if (shift_in[g]) begin
						score_q[g] <= score_q[(g > 0) ? g - 1 : 0];
						tag_q[g]   <= tag_q[(g > 0) ? g - 1 : 0];
					end
				end
			end
		end
	endgenerate

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			new_score_q <= new_score;
			new_tag_q   <= new_tag;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			rank_q  <= '0;
		end else begin
			if (cmd.insert && !full) count_q <= count_q + CW'(1);
			if (cmd.load) begin
				rank_q <= '0;
			end else if (cmd.rank_inc) begin
				rank_q <= rank_q + tksi_pkg::IDX_W'(1);
			end
		end
	end

	assign sts.last  = ((CW'(rank_q) + CW'(1)) == count_q);
	assign sts.count = count_q;

	assign rank        = tksi_pkg::RANK_W'(rank_q);
	assign entry_score = score_q[rank_q];
	assign entry_tag   = tag_q[rank_q];
	assign last_entry  = sts.last;

endmodule

// ===== rtl/core/top_k_sorted_insert_unit.sv =====
// top level of the top-k sorted insert unit
//
// channel  dir  payload                                      beats per item
// offer    in   new_score, new_tag                           1
// result   out  rank, entry_score, entry_tag, last_entry     list size (1..8)
//
// without stalls, an item is handled in order: the offer beat is taken, then it is merged
// into the list, then one result beat goes out per listed entry.
// the merge is a compare-and-shift across all list slots, done in the insert state.
// reset clears the entry count; list contents are only read below the count.
// result stalls hold the current rank; no new offer is taken until the run ends.
`include "top_k_sorted_insert_unit_assert.svh"

module top_k_sorted_insert_unit (
	input  logic          clk,
	input  logic          arst_n,
	tksi_offer_if.sink    offer,
	tksi_result_if.source result
);

	tksi_pkg::cmd_t cmd;
	tksi_pkg::sts_t sts;

	tksi_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.offer_valid  (offer.valid),
		.offer_ready  (offer.ready),
		.result_valid (result.valid),
		.result_ready (result.ready),
		.sts          (sts),
		.cmd          (cmd)
	);

	tksi_datapath u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.new_score   (offer.new_score),
		.new_tag     (offer.new_tag),
		.rank        (result.rank),
		.entry_score (result.entry_score),
		.entry_tag   (result.entry_tag),
		.last_entry  (result.last_entry)
	);

	`TKSI_ASSERT_NOW(a_no_overlap, clk, arst_n, offer.ready, !result.valid)
	`TKSI_ASSERT_NEXT(a_merge_gap, clk, arst_n, offer.valid && offer.ready, !offer.ready && !result.valid)
	`TKSI_ASSERT_NEXT(a_run_end, clk, arst_n, result.valid && result.ready && result.last_entry, offer.ready)
	`TKSI_ASSERT_NOW(a_count_bound, clk, arst_n, 1'b1, sts.count <= tksi_pkg::CNT_W'(tksi_pkg::LIST_DEPTH))

endmodule

// ===== tb/sv/top_k_sorted_insert_unit_test.sv =====
// testbench for the top-k sorted insert unit: random offers checked against a list predictor
`timescale 1ns / 100ps

module top_k_sorted_insert_unit_test;

	localparam int IDLE_LIMIT = 2000;
	localparam int HOLD_CYCLES = 400;
	localparam int RANDOM_ITEMS = 160;

	typedef enum int {STALL_NONE, STALL_COIN, STALL_EVERY4, STALL_RARE} stall_mode_t;

	typedef struct {
		tksi_pkg::score_t score;
		tksi_pkg::tag_t   tag;
		bit               drain_first;
	} offer_item_t;

	typedef struct {
		tksi_pkg::rank_t  rank;
		tksi_pkg::score_t score;
		tksi_pkg::tag_t   tag;
		logic             last;
	} ranked_entry_t;

	logic clk;
	logic arst_n;

	tksi_offer_if  offer_ch ();
	tksi_result_if result_ch ();

	top_k_sorted_insert_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.offer  (offer_ch),
		.result (result_ch)
	);

	offer_item_t   offer_items[$];
	ranked_entry_t ranked_expect[$];

	// predictor copy of the list
	tksi_pkg::score_t list_score[tksi_pkg::LIST_DEPTH];
	tksi_pkg::tag_t   list_tag[tksi_pkg::LIST_DEPTH];
	int unsigned      list_len;

	int          offers_taken;
	int          mismatches;
	int          idle_cycles;
	bit          stalled_out;
	int          burst_left;
	int          gap_left;
	int          hold_left;
	bit          hold_done;
	int          stall_phase;
	stall_mode_t stall_mode;

	// merge one offered entry into the list and queue the full ranked run
	task automatic rank_offer(input tksi_pkg::score_t s, input tksi_pkg::tag_t t);
		bit          take;
		int unsigned free_slot;
		int unsigned pos;
		ranked_entry_t e;
		take = 1'b0;
		free_slot = 0;
		if (list_len < tksi_pkg::LIST_DEPTH) begin
			take = 1'b1;
			free_slot = list_len;
			list_len++;
		end else if (s > list_score[tksi_pkg::LIST_DEPTH-1]) begin
			take = 1'b1;
			free_slot = tksi_pkg::LIST_DEPTH - 1;
		end
		if (take) begin
			pos = 0;
			// equal scores stay ahead of the newcomer
			while (pos < free_slot && list_score[pos] >= s)
				pos++;
			for (int k = free_slot; k > pos; k--) begin
				list_score[k] = list_score[k-1];
				list_tag[k] = list_tag[k-1];
			end
			list_score[pos] = s;
			list_tag[pos] = t;
		end
		for (int k = 0; k < list_len; k++) begin
			e.rank = tksi_pkg::rank_t'(k);
			e.score = list_score[k];
			e.tag = list_tag[k];
			e.last = (k + 1 == list_len);
			ranked_expect.push_back(e);
		end
	endtask

	task automatic queue_offer(input tksi_pkg::score_t s, input tksi_pkg::tag_t t,
			input bit drain);
		offer_item_t it;
		it.score = s;
		it.tag = t;
		it.drain_first = drain;
		offer_items.push_back(it);
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// sender: bursts of beats with random gaps
	always @(posedge clk or negedge arst_n) begin
		offer_item_t it;
		bit          send;
		if (!arst_n) begin
			offer_ch.valid <= 1'b0;
			offer_ch.new_score <= '0;
			offer_ch.new_tag <= '0;
			burst_left = 0;
			gap_left = 0;
		end else begin
			if (offer_ch.valid && offer_ch.ready) begin
				rank_offer(offer_ch.new_score, offer_ch.new_tag);
				offers_taken++;
			end
			if (!offer_ch.valid || offer_ch.ready) begin
				send = 1'b0;
				if (gap_left > 0)
					gap_left--;
				else if (offer_items.size() > 0 &&
						!(offer_items[0].drain_first && ranked_expect.size() != 0))
					send = 1'b1;
				if (send) begin
					it = offer_items.pop_front();
					offer_ch.valid <= 1'b1;
					offer_ch.new_score <= it.score;
					offer_ch.new_tag <= it.tag;
					if (burst_left > 0)
						burst_left--;
					else begin
						burst_left = $urandom_range(1, 12);
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
					end
				end else begin
					offer_ch.valid <= 1'b0;
				end
			end
		end
	end

	// receiver: stall pattern of its own, plus one long hold-off
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_ch.ready <= 1'b0;
			hold_left = 0;
			hold_done = 1'b0;
			stall_phase = 0;
			stall_mode = STALL_NONE;
		end else begin
			stall_phase++;
			if (!hold_done && offers_taken >= 50) begin
				hold_left = HOLD_CYCLES;
				hold_done = 1'b1;
			end
			if (hold_left > 0) begin
				hold_left--;
				result_ch.ready <= 1'b0;
			end else begin
				if (stall_phase % 50 == 0)
					stall_mode = stall_mode_t'($urandom_range(0, 3));
				case (stall_mode)
					STALL_NONE: result_ch.ready <= 1'b1;
					STALL_COIN: result_ch.ready <= 1'($urandom_range(0, 1));
					STALL_EVERY4: result_ch.ready <= (stall_phase % 4 == 3);
					default: result_ch.ready <= ($urandom_range(0, 7) != 0);
				endcase
			end
		end
	end

	// monitor and watchdog
	always @(posedge clk or negedge arst_n) begin
		ranked_entry_t want;
		if (!arst_n) begin
			idle_cycles = 0;
		end else begin
			if ((offer_ch.valid && offer_ch.ready) || (result_ch.valid && result_ch.ready))
				idle_cycles = 0;
			else if (idle_cycles < IDLE_LIMIT)
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT)
				stalled_out = 1'b1;
			if (result_ch.valid && result_ch.ready) begin
				if (ranked_expect.size() == 0) begin
					mismatches++;
					$display("%0t: unexpected beat rank %0d score %0d tag %h last %b", $time,
						result_ch.rank, result_ch.entry_score, result_ch.entry_tag,
						result_ch.last_entry);
				end else begin
					want = ranked_expect.pop_front();
					if (result_ch.rank !== want.rank || result_ch.entry_score !== want.score ||
							result_ch.entry_tag !== want.tag ||
							result_ch.last_entry !== want.last) begin
						mismatches++;
						$display({"%0t: expected rank %0d score %0d tag %h last %b, ",
							"got rank %0d score %0d tag %h last %b"},
							$time, want.rank, want.score, want.tag, want.last,
							result_ch.rank, result_ch.entry_score, result_ch.entry_tag,
							result_ch.last_entry);
					end
				end
			end
		end
	end

	initial begin
		int               pick;
		tksi_pkg::score_t s;
		tksi_pkg::tag_t   t;
		arst_n = 1'b0;
		offer_ch.valid = 1'b0;
		offer_ch.new_score = '0;
		offer_ch.new_tag = '0;
		result_ch.ready = 1'b0;
		list_len = 0;
		offers_taken = 0;
		mismatches = 0;
		stalled_out = 1'b0;

		// directed: empty list, ties, extremes, full list reject and replace
		queue_offer(5, 16'h0001, 1'b0);
		queue_offer(5, 16'h0002, 1'b0);
		queue_offer(32'sh7FFF_FFFF, 16'hFFFF, 1'b0);
		queue_offer(32'sh8000_0000, 16'h0000, 1'b0);
		queue_offer(5, 16'h0003, 1'b0);
		queue_offer(0, 16'h8000, 1'b0);
		queue_offer(-1, 16'h7FFF, 1'b0);
		queue_offer(100, 16'hAAAA, 1'b0);
		// list is full from here
		queue_offer(32'sh8000_0000, 16'h5555, 1'b0);
		queue_offer(-5, 16'h1234, 1'b0);
		queue_offer(-1, 16'h4321, 1'b0);
		queue_offer(-1, 16'h0F0F, 1'b0);
		queue_offer(32'sh7FFF_FFFF, 16'hF0F0, 1'b0);
		queue_offer(5, 16'h0009, 1'b1);
		queue_offer(32'sh7FFF_FFFE, 16'hFFFF, 1'b0);
		queue_offer(32'sh8000_0001, 16'h0000, 1'b0);

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			pick = $urandom_range(0, 99);
			if (pick < 40)
				s = tksi_pkg::score_t'(32'h7FFF_FFFF - $urandom_range(0, 40));
			else if (pick < 65)
				s = tksi_pkg::score_t'($urandom);
			else if (pick < 80)
				s = ($urandom_range(0, 1) != 0) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
			else
				s = tksi_pkg::score_t'(int'($urandom_range(0, 40)) - 20);
			pick = $urandom_range(0, 9);
			if (pick == 0)
				t = '0;
			else if (pick == 1)
				t = '1;
			else
				t = tksi_pkg::tag_t'($urandom);
			queue_offer(s, t, (i == 80 || i == 130 || $urandom_range(0, 49) == 0));
		end

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// wait for every beat offered and every ranked entry returned
		do
			@(negedge clk);
		while (!stalled_out && (offer_items.size() != 0 || offer_ch.valid ||
			ranked_expect.size() != 0));
		if (!stalled_out)
			repeat (20) @(negedge clk);

		if (stalled_out || mismatches != 0 || ranked_expect.size() != 0)
			$display("Simulation FAILED");
		else
			$display("Simulation PASSED");
		$finish;
	end

endmodule
